// File: src/aac_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and the controller command type for the activity classifier.
// No dependencies.
package aac_pkg;

  localparam int AXIS_W     = 16;
  localparam int NUM_AXES   = 3;
  localparam int SQ_W       = 32;
  localparam int ROOT_W     = 16;
  localparam int REM_W      = ROOT_W + 2;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int CNT_W      = $clog2(ROOT_STEPS);
  localparam int THR_W      = 16;
  localparam int COUNT_W    = 32;
  localparam int TOTAL_W    = COUNT_W + 1;
  localparam int CLASS_W    = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int WINDOW_DEF = 5;

  localparam logic [THR_W-1:0] LOW_THR_RST  = THR_W'(255);
  localparam logic [THR_W-1:0] HIGH_THR_RST = THR_W'(382);

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_IDX  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_IDX = CFG_IDX_W'(1);

  typedef enum logic [CLASS_W-1:0] {
    CLS_INACTIVE = 2'd0,
    CLS_ACTIVE   = 2'd1,
    CLS_HIGH     = 2'd2
  } class_t;

  typedef struct packed {
    logic capture;
    logic square;
    logic root;
    logic classify;
    logic load_out;
  } cmd_t;

endpackage

// File: src/aac_if.sv
`timescale 1ns / 1ps
// Handshake channels of the activity classifier: sample input, result output, register writes.
// Depends on aac_pkg.
interface aac_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [aac_pkg::AXIS_W-1:0]    accel_x;
  logic signed [aac_pkg::AXIS_W-1:0]    accel_y;
  logic signed [aac_pkg::AXIS_W-1:0]    accel_z;

  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface aac_out_if;
  logic                           valid;
  logic                           ready;
  logic [aac_pkg::CLASS_W-1:0]    activity_class;
  logic [aac_pkg::ROOT_W-1:0]     magnitude;
  logic [aac_pkg::COUNT_W-1:0]    class_count;
  logic [aac_pkg::TOTAL_W-1:0]    moving_total;

  modport source (output valid, activity_class, magnitude, class_count, moving_total,
                  input ready);
  modport sink   (input valid, activity_class, magnitude, class_count, moving_total,
                  output ready);
endinterface

interface aac_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [aac_pkg::CFG_IDX_W-1:0]     index;
  logic [aac_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/aac_ctrl.sv
`timescale 1ns / 1ps
// Sequencing controller: steps one item through squaring, root, classification and output load.
// Depends on aac_pkg.
module aac_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  output aac_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_CLASS,
    ST_LOAD
  } state_t;

  state_t                      state_r, state_nxt;
  logic [aac_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        accept;
  logic                        can_load;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign can_load  = !out_valid_r || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.capture  = accept;
    cmd.square   = (state_r == ST_SQUARE);
    cmd.root     = (state_r == ST_ROOT);
    cmd.classify = (state_r == ST_CLASS);
    cmd.load_out = (state_r == ST_LOAD) && can_load;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SQUARE;
          cnt_nxt   = '0;
        end
      end
      ST_SQUARE: begin
        if (cnt_r == aac_pkg::CNT_W'(aac_pkg::NUM_AXES - 1)) begin
          state_nxt = ST_ROOT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ROOT: begin
        if (cnt_r == aac_pkg::CNT_W'(aac_pkg::ROOT_STEPS - 1)) begin
          state_nxt = ST_CLASS;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_CLASS: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (can_load) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("output loaded over an untaken item");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("result dropped while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("second item taken while busy");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_LOAD))
    else $error("result raised outside load");

endmodule

// File: src/aac_datapath.sv
`timescale 1ns / 1ps
// Datapath: shared squarer, bit-serial square root, magnitude window, class counters, outputs.
// Depends on aac_pkg.
module aac_datapath #(
  parameter int WINDOW = aac_pkg::WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  aac_pkg::cmd_t                        cmd,
  input  logic signed [aac_pkg::AXIS_W-1:0]    accel_x,
  input  logic signed [aac_pkg::AXIS_W-1:0]    accel_y,
  input  logic signed [aac_pkg::AXIS_W-1:0]    accel_z,
  input  logic                                 cfg_we,
  input  logic [aac_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [aac_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic [aac_pkg::CLASS_W-1:0]          activity_class,
  output logic [aac_pkg::ROOT_W-1:0]           magnitude,
  output logic [aac_pkg::COUNT_W-1:0]          class_count,
  output logic [aac_pkg::TOTAL_W-1:0]          moving_total
);

  localparam int SUM_W = aac_pkg::ROOT_W + $clog2(WINDOW);
  localparam int SH_W  = aac_pkg::REM_W + 2;

  logic [aac_pkg::AXIS_W-1:0]   ax_r [aac_pkg::NUM_AXES];
  logic [aac_pkg::SQ_W-1:0]     acc_r;
  logic [aac_pkg::ROOT_W-1:0]   root_r;
  logic [aac_pkg::REM_W-1:0]    rem_r;
  logic [aac_pkg::THR_W-1:0]    low_thr_r, high_thr_r;
  logic [aac_pkg::ROOT_W-1:0]   win_r [WINDOW];
  logic [SUM_W-1:0]             sum_r;
  logic [aac_pkg::COUNT_W-1:0]  inact_cnt_r, act_cnt_r, high_cnt_r, count_r;
  aac_pkg::class_t              cls_r;
  logic [aac_pkg::CLASS_W-1:0]  out_cls_r;
  logic [aac_pkg::ROOT_W-1:0]   out_mag_r;
  logic [aac_pkg::COUNT_W-1:0]  out_cnt_r;
  logic [aac_pkg::TOTAL_W-1:0]  out_total_r;

  logic [aac_pkg::SQ_W-1:0]     square;
  logic [SH_W-1:0]              rem_sh, trial;
  logic                         root_bit;
  logic [SUM_W-1:0]             sum_nxt, low_lim, high_lim;
  aac_pkg::class_t              cls_nxt;

  function automatic logic [aac_pkg::AXIS_W-1:0] abs_axis(
    input logic signed [aac_pkg::AXIS_W-1:0] v);
    logic [aac_pkg::AXIS_W-1:0] u;
    u = v;
    return v[aac_pkg::AXIS_W-1] ? (~u + 1'b1) : u;
  endfunction

  function automatic logic [aac_pkg::COUNT_W-1:0] sat_inc(
    input logic [aac_pkg::COUNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  assign square   = ax_r[0] * ax_r[0];
  assign rem_sh   = {rem_r, acc_r[aac_pkg::SQ_W-1 -: 2]};
  assign trial    = {2'b00, root_r, 2'b01};
  assign root_bit = (rem_sh >= trial);

  assign sum_nxt  = sum_r - SUM_W'(win_r[0]) + SUM_W'(root_r);
  assign low_lim  = SUM_W'(low_thr_r) * SUM_W'(WINDOW);
  assign high_lim = SUM_W'(high_thr_r) * SUM_W'(WINDOW);

  always_comb begin
    if (sum_nxt < low_lim) begin
      cls_nxt = aac_pkg::CLS_INACTIVE;
    end else if (sum_nxt < high_lim) begin
      cls_nxt = aac_pkg::CLS_ACTIVE;
    end else begin
      cls_nxt = aac_pkg::CLS_HIGH;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_thr_r  <= aac_pkg::LOW_THR_RST;
      high_thr_r <= aac_pkg::HIGH_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aac_pkg::CFG_LOW_IDX:  low_thr_r  <= aac_pkg::THR_W'(cfg_data);
        aac_pkg::CFG_HIGH_IDX: high_thr_r <= aac_pkg::THR_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // squaring and square root
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ax_r[0] <= abs_axis(accel_x);
      ax_r[1] <= abs_axis(accel_y);
      ax_r[2] <= abs_axis(accel_z);
      acc_r   <= '0;
      root_r  <= '0;
      rem_r   <= '0;
    end else if (cmd.square) begin
      acc_r <= acc_r + square;
      for (int i = 0; i < aac_pkg::NUM_AXES - 1; i++) begin
        ax_r[i] <= ax_r[i+1];
      end
      ax_r[aac_pkg::NUM_AXES-1] <= ax_r[0];
    end else if (cmd.root) begin
      acc_r  <= {acc_r[aac_pkg::SQ_W-3:0], 2'b00};
      root_r <= {root_r[aac_pkg::ROOT_W-2:0], root_bit};
      rem_r  <= root_bit ? aac_pkg::REM_W'(rem_sh - trial) : aac_pkg::REM_W'(rem_sh);
    end
  end

  // window, running sum and class counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        win_r[i] <= '0;
      end
      sum_r       <= '0;
      inact_cnt_r <= '0;
      act_cnt_r   <= '0;
      high_cnt_r  <= '0;
    end else if (cmd.classify) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WINDOW-1] <= root_r;
      sum_r           <= sum_nxt;
      case (cls_nxt)
        aac_pkg::CLS_INACTIVE: inact_cnt_r <= sat_inc(inact_cnt_r);
        aac_pkg::CLS_ACTIVE:   act_cnt_r   <= sat_inc(act_cnt_r);
        default:               high_cnt_r  <= sat_inc(high_cnt_r);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      cls_r <= cls_nxt;
      case (cls_nxt)
        aac_pkg::CLS_INACTIVE: count_r <= sat_inc(inact_cnt_r);
        aac_pkg::CLS_ACTIVE:   count_r <= sat_inc(act_cnt_r);
        default:               count_r <= sat_inc(high_cnt_r);
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_cls_r   <= cls_r;
      out_mag_r   <= root_r;
      out_cnt_r   <= count_r;
      out_total_r <= {1'b0, act_cnt_r} + {1'b0, high_cnt_r};
    end
  end

  assign activity_class = out_cls_r;
  assign magnitude      = out_mag_r;
  assign class_count    = out_cnt_r;
  assign moving_total   = out_total_r;

endmodule

// File: src/accel_activity_classifier_top.sv
`timescale 1ns / 1ps
// Top level of the accelerometer activity classifier.
// Depends on aac_pkg, aac_if, aac_ctrl and aac_datapath.
//
// Channels: in_ch takes one signed three-axis sample per item; out_ch returns one result
// item per sample (class, magnitude, updated class count, active plus highly active total);
// cfg_ch writes low_threshold (index 0) and high_threshold (index 1), always ready.
// Other indexes are ignored. Write registers only while no item is in flight.
// Sequence: the sample is captured at the accepting edge, then the shared 16x16 squarer works
// through the three axes, then the one-bit-per-cycle square root, one classify and one output
// load. A new item is taken only after the previous one reaches its output load; in_ch is
// ready only while the controller is idle, which it reaches after the output load.
// Reset (rst_n low, synchronous): thresholds to 255 and 382, window, running sum and
// class counters to zero, no result pending.
// Stall: the result sits in an output register while out_ch is not ready; the next item is
// taken and processed meanwhile and waits at its load step until the register frees up.
// WINDOW sets the number of magnitudes averaged (1 to 32).
module accel_activity_classifier_top #(
  parameter int WINDOW = aac_pkg::WINDOW_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  aac_in_if.sink        in_ch,
  aac_out_if.source     out_ch,
  aac_cfg_if.sink       cfg_ch
);

  aac_pkg::cmd_t cmd;

  assign cfg_ch.ready = 1'b1;

  aac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  aac_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .accel_x        (in_ch.accel_x),
    .accel_y        (in_ch.accel_y),
    .accel_z        (in_ch.accel_z),
    .cfg_we         (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .activity_class (out_ch.activity_class),
    .magnitude      (out_ch.magnitude),
    .class_count    (out_ch.class_count),
    .moving_total   (out_ch.moving_total)
  );

endmodule

// File: tb/sv/accel_activity_classifier_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for accel_activity_classifier_top: drives samples and threshold writes,
// predicts class, magnitude and counts per item, checks every result in order.
// Depends on aac_pkg, aac_if and the classifier RTL.
module accel_activity_classifier_top_tb;

  localparam int WINDOW_LEN   = aac_pkg::WINDOW_DEF;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 70;
  localparam int SEG_ITEMS    = 200;
  localparam int TIMEOUT_NS   = 1_000_000;

  localparam logic [aac_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = aac_pkg::CFG_IDX_W'(2);

  typedef struct packed {
    logic signed [aac_pkg::AXIS_W-1:0] x;
    logic signed [aac_pkg::AXIS_W-1:0] y;
    logic signed [aac_pkg::AXIS_W-1:0] z;
  } sample_t;

  typedef struct packed {
    aac_pkg::class_t             cls;
    logic [aac_pkg::ROOT_W-1:0]  mag;
    logic [aac_pkg::COUNT_W-1:0] count;
    logic [aac_pkg::TOTAL_W-1:0] total;
  } activity_t;

  typedef enum int {LVL_REST, LVL_WALK, LVL_RUN, LVL_FULL} level_t;

  logic clk;
  logic rst_n;

  aac_in_if  sample_ch ();
  aac_out_if result_ch ();
  aac_cfg_if thr_ch ();

  accel_activity_classifier_top #(.WINDOW(WINDOW_LEN)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (sample_ch),
    .out_ch (result_ch),
    .cfg_ch (thr_ch)
  );

  // predictor state
  logic [aac_pkg::THR_W-1:0]   low_thr = aac_pkg::LOW_THR_RST;
  logic [aac_pkg::THR_W-1:0]   high_thr = aac_pkg::HIGH_THR_RST;
  logic [aac_pkg::ROOT_W-1:0]  mag_hist [WINDOW_LEN] = '{default: '0};
  logic [18:0]                 mag_sum = '0;
  logic [aac_pkg::COUNT_W-1:0] quiet_count = '0;
  logic [aac_pkg::COUNT_W-1:0] moving_count = '0;
  logic [aac_pkg::COUNT_W-1:0] vigorous_count = '0;

  sample_t   samples_to_send[$];
  activity_t activity_due[$];

  bit   offering = 1'b0;
  logic in_fire = 1'b0;
  int   cfg_writes = 0;
  int   mismatch_count = 0;
  int   results_seen = 0;
  int   send_idle_pct = 25;
  int   recv_idle_pct = 64;

  bit hold_req = 1'b0;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic activity_t predict_activity(input sample_t s);
    activity_t                   r;
    longint                      ax, ay, az;
    longint unsigned             sq;
    logic [aac_pkg::ROOT_W:0]    root, trial;
    ax = $signed(s.x);
    ay = $signed(s.y);
    az = $signed(s.z);
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    if (az < 0) az = -az;
    sq = ax * ax + ay * ay + az * az;
    root = '0;
    for (int b = aac_pkg::ROOT_W; b >= 0; b--) begin
      trial = root | ((aac_pkg::ROOT_W+1)'(1) << b);
      if (longint'(trial) * longint'(trial) <= sq) root = trial;
    end
    mag_sum = mag_sum - mag_hist[0];
    for (int i = 0; i + 1 < WINDOW_LEN; i++) mag_hist[i] = mag_hist[i+1];
    mag_hist[WINDOW_LEN-1] = root[aac_pkg::ROOT_W-1:0];
    mag_sum = mag_sum + root[aac_pkg::ROOT_W-1:0];
    r.mag = root[aac_pkg::ROOT_W-1:0];
    if (longint'(mag_sum) < longint'(low_thr) * WINDOW_LEN) begin
      if (quiet_count != '1) quiet_count++;
      r.cls = aac_pkg::CLS_INACTIVE;
      r.count = quiet_count;
    end else if (longint'(mag_sum) < longint'(high_thr) * WINDOW_LEN) begin
      if (moving_count != '1) moving_count++;
      r.cls = aac_pkg::CLS_ACTIVE;
      r.count = moving_count;
    end else begin
      if (vigorous_count != '1) vigorous_count++;
      r.cls = aac_pkg::CLS_HIGH;
      r.count = vigorous_count;
    end
    r.total = {1'b0, moving_count} + {1'b0, vigorous_count};
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t result %0d %s: got %0d, expected %0d", $time, results_seen, what, got, want);
    mismatch_count++;
  endtask

  // sample sender
  always @(negedge clk) begin : drive_samples
    sample_t nxt;
    if (!rst_n) begin
      sample_ch.valid <= 1'b0;
    end else begin
      if (in_fire) offering = 1'b0;
      if (!offering && samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = samples_to_send.pop_front();
        sample_ch.accel_x <= nxt.x;
        sample_ch.accel_y <= nxt.y;
        sample_ch.accel_z <= nxt.z;
        offering = 1'b1;
      end
      sample_ch.valid <= offering;
    end
  end

  // result receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (hold_req && !hold_armed) begin
        hold_armed = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        if (hold_left == 0) hold_done = 1'b1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : observe
    sample_t   s;
    activity_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= sample_ch.valid && sample_ch.ready;
      if (thr_ch.valid && thr_ch.ready) begin
        if (thr_ch.index == aac_pkg::CFG_LOW_IDX) low_thr = thr_ch.data;
        else if (thr_ch.index == aac_pkg::CFG_HIGH_IDX) high_thr = thr_ch.data;
        cfg_writes <= cfg_writes + 1;
      end
      if (sample_ch.valid && sample_ch.ready) begin
        s.x = sample_ch.accel_x;
        s.y = sample_ch.accel_y;
        s.z = sample_ch.accel_z;
        activity_due.push_back(predict_activity(s));
      end
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (activity_due.size() == 0) begin
          report_mismatch("result with none due", result_ch.magnitude, 0);
        end else begin
          want = activity_due.pop_front();
          if (result_ch.activity_class !== want.cls)
            report_mismatch("activity_class", result_ch.activity_class, want.cls);
          if (result_ch.magnitude !== want.mag)
            report_mismatch("magnitude", result_ch.magnitude, want.mag);
          if (result_ch.class_count !== want.count)
            report_mismatch("class_count", result_ch.class_count, want.count);
          if (result_ch.moving_total !== want.total)
            report_mismatch("moving_total", result_ch.moving_total, want.total);
        end
      end
    end
  end

  task automatic write_register(input logic [aac_pkg::CFG_IDX_W-1:0] idx,
                                input logic [aac_pkg::CFG_DATA_W-1:0] value);
    int target;
    target = cfg_writes + 1;
    @(negedge clk);
    thr_ch.valid <= 1'b1;
    thr_ch.index <= idx;
    thr_ch.data  <= value;
    while (cfg_writes < target) @(negedge clk);
    thr_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (samples_to_send.size() != 0 || offering || activity_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic queue_sample(input int x, input int y, input int z);
    sample_t s;
    s.x = aac_pkg::AXIS_W'(x);
    s.y = aac_pkg::AXIS_W'(y);
    s.z = aac_pkg::AXIS_W'(z);
    samples_to_send.push_back(s);
  endtask

  function automatic logic signed [aac_pkg::AXIS_W-1:0] random_axis(input level_t lvl);
    int m;
    case (lvl)
      LVL_REST: m = $urandom_range(200);
      LVL_WALK: m = $urandom_range(1000);
      LVL_RUN:  m = $urandom_range(12000);
      default:  return aac_pkg::AXIS_W'($urandom);
    endcase
    return aac_pkg::AXIS_W'($urandom_range(1) ? -m : m);
  endfunction

  // bursts at one level so the window average settles, with stray noise items
  task automatic queue_bursts(input int n_items);
    int     queued;
    int     len;
    level_t lvl;
    sample_t s;
    queued = 0;
    while (queued < n_items) begin
      lvl = level_t'($urandom_range(3));
      len = $urandom_range(3, 15);
      repeat (len) begin
        if ($urandom_range(9) == 0) begin
          s.x = random_axis(LVL_FULL);
          s.y = random_axis(LVL_FULL);
          s.z = random_axis(LVL_FULL);
        end else begin
          s.x = random_axis(lvl);
          s.y = random_axis(lvl);
          s.z = random_axis(lvl);
        end
        samples_to_send.push_back(s);
        queued++;
      end
    end
  endtask

  task automatic run_segment(input int lo, input int hi, input int snd_pct, input int rcv_pct,
                             input bit with_hold);
    wait_idle();
    write_register(aac_pkg::CFG_LOW_IDX, aac_pkg::CFG_DATA_W'(lo));
    write_register(aac_pkg::CFG_HIGH_IDX, aac_pkg::CFG_DATA_W'(hi));
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    queue_bursts(SEG_ITEMS);
    if (with_hold) begin
      hold_req = 1'b1;
      while (!hold_done) @(negedge clk);
    end
    wait_idle();
  endtask

  initial begin
    int        lo, hi;
    activity_t left;
    rst_n = 1'b0;
    sample_ch.valid = 1'b0;
    sample_ch.accel_x = '0;
    sample_ch.accel_y = '0;
    sample_ch.accel_z = '0;
    result_ch.ready = 1'b0;
    thr_ch.valid = 1'b0;
    thr_ch.index = '0;
    thr_ch.data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // warm-up from a zeroed window at reset thresholds, then the extremes
    queue_sample(300, 300, 300);
    queue_sample(0, 0, 0);
    queue_sample(-32768, -32768, -32768);
    queue_sample(32767, 32767, 32767);
    queue_sample(-32768, 32767, -32768);
    queue_sample(-32768, 0, 0);
    queue_sample(0, 32767, 0);
    queue_sample(0, 0, -1);
    queue_sample(1, -1, 1);
    queue_sample(-1, -1, -1);
    queue_sample(255, 0, 0);
    queue_sample(0, 255, 0);
    queue_sample(0, 0, 382);
    queue_sample(-220, 150, 100);
    queue_sample(0, 0, 0);
    queue_sample(0, 0, 0);
    queue_sample(0, 0, 0);
    queue_sample(0, 0, 0);
    queue_sample(0, 0, 0);
    queue_sample(21845, -21846, 10922);
    wait_idle();

    run_segment(0, 0, 25, 64, 1'b0);
    run_segment(65535, 65535, 25, 64, 1'b0);
    // crossed thresholds: anything not inactive is highly active
    run_segment(3000, 1000, 64, 25, 1'b0);
    run_segment(600, 9000, 64, 25, 1'b0);
    run_segment(1500, 20000, 0, 0, 1'b1);
    write_register(CFG_SPARE_IDX, aac_pkg::CFG_DATA_W'($urandom));
    lo = $urandom_range(4000);
    hi = $urandom_range(40000, lo);
    run_segment(lo, hi, 0, 0, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    while (activity_due.size() != 0) begin
      left = activity_due.pop_front();
      report_mismatch("result never came", left.mag, 0);
    end
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
src/aac_pkg.sv
src/aac_if.sv
src/aac_ctrl.sv
src/aac_datapath.sv
src/accel_activity_classifier_top.sv
tb/sv/accel_activity_classifier_top_tb.sv
